/* hdl/fmd_pkg.sv */
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared types, register codes and constants of the frame motion detector.
// ----------------------------------------------------------------------------
package fmd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RAD   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd3;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [1:0]  RST_WINDOW_RAD   = 2'd1;
    localparam logic [16:0] RST_THRESHOLD    = 17'd6554;

    // gray weights in Q16
    localparam logic [15:0] COEF_R   = 16'd19589;
    localparam logic [15:0] COEF_G   = 16'd38470;
    localparam logic [15:0] COEF_B   = 16'd7471;
    localparam logic [23:0] GRAY_RND = 24'd32768;

    // mean = (sum * recip) >> RECIP_SHIFT, exact for every window sum
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 24;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] reference_level;
    } fmd_in_t;

    typedef struct packed {
        logic [22:0] differing_pixels;
        logic        frame_differs;
        logic [31:0] flagged_frames;
    } fmd_out_t;

    // ceil(2^24 / (2r+1)^2) for radius 1 to 7; radius 0 gets the radius-1 value
    function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] radius);
        logic [RECIP_W-1:0] m;
        case (radius)
            3'd2:    m = 21'd671089;
            3'd3:    m = 21'd342393;
            3'd4:    m = 21'd207127;
            3'd5:    m = 21'd138655;
            3'd6:    m = 21'd99274;
            3'd7:    m = 21'd74566;
            default: m = 21'd1864136;
        endcase
        return m;
    endfunction

endpackage

/* hdl/fmd_cell.sv */
// ----------------------------------------------------------------------------
// fmd_cell
// One column slot of the window row: holds a column sum and a level byte,
// takes its neighbor's contents on each advance, empties at row start.
// ----------------------------------------------------------------------------
module fmd_cell #(
    parameter int DATA_W = 19
) (
    input  logic              aclk,
    input  logic              shift_en,
    input  logic              clear,
    input  logic [DATA_W-1:0] d,
    output logic [DATA_W-1:0] q
);

    logic [DATA_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= clear ? '0 : d;
        end
    end

    assign q = data_reg;

endmodule

/* hdl/frame_motion_detector_core.sv */
// ----------------------------------------------------------------------------
// frame_motion_detector_core
// Gray conversion, zero-padded box average, background compare and per-frame
// motion decision over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage: pixels enter on s_valid/s_ready/s_data in raster order, one transfer
// per pixel with its background level. One result leaves on m_valid/m_ready/
// m_data after the last pixel of each frame. Geometry and threshold are
// written on the cfg port while idle and latch at the first pixel of a frame.
// Each frame is scanned over (W+r) x (H+r) positions, one per cycle: the
// r extra columns and rows feed zeros to finish the border windows, and
// s_ready is low during them. Inside the frame a pixel is taken every cycle
// that s_valid is high. The result passes from the last scan position through
// the stage registers, the drain and emit states and the result register. A
// finished frame holds with s_ready low until the output register is free,
// so while a result waits the next frame still scans and stops only at its
// own end. Reset clears the position, counters, output valid flag and
// registers the configuration defaults; the line memories need no clearing.
// ----------------------------------------------------------------------------
module frame_motion_detector_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_RADIUS = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fmd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fmd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fmd_pkg::fmd_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output fmd_pkg::fmd_out_t                 m_data
);

    import fmd_pkg::*;

    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int PXW    = $clog2(MAX_WIDTH + MAX_RADIUS);
    localparam int PYW    = $clog2(MAX_HEIGHT + MAX_RADIUS);
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int TAPS   = 2 * MAX_RADIUS + 1;
    localparam int CIW    = $clog2(TAPS);
    localparam int CSW    = $clog2(255 * TAPS + 1);
    localparam int WSW    = $clog2(255 * TAPS * TAPS + 1);
    localparam int CDW    = CSW + 8;
    localparam int PRW    = WSW + RECIP_W;
    localparam int AREA_W = WW + HW;
    localparam int HALF   = AREA_W / 2;
    localparam int THR_W  = 17;
    localparam int RHS_W  = THR_W + AREA_W + 1;
    localparam int CMP_W  = (RHS_W > 39) ? RHS_W : 39;

    localparam logic [1:0] ST_SCAN  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    // configuration
    logic [11:0] frame_width_reg, frame_height_reg;
    logic [1:0]  window_radius_reg;
    logic [16:0] threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
            window_radius_reg <= RST_WINDOW_RAD;
            threshold_reg     <= RST_THRESHOLD;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg   <= cfg_wdata[11:0];
                REG_FRAME_HEIGHT: frame_height_reg  <= cfg_wdata[11:0];
                REG_WINDOW_RAD:   window_radius_reg <= cfg_wdata[1:0];
                REG_THRESHOLD:    threshold_reg     <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [RW-1:0] r_eff;

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (int'(frame_width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = HW'(1);
        end else if (int'(frame_height_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(frame_height_reg);
        end
        if (window_radius_reg == '0) begin
            r_eff = RW'(1);
        end else if (int'(window_radius_reg) > MAX_RADIUS) begin
            r_eff = RW'(MAX_RADIUS);
        end else begin
            r_eff = RW'(window_radius_reg);
        end
    end

    // scan control
    logic [1:0]     state_reg;
    logic [PXW-1:0] vx_reg;
    logic [PYW-1:0] vy_reg;
    logic [WW-1:0]  act_w_reg;
    logic [HW-1:0]  act_h_reg;
    logic [RW-1:0]  act_r_reg;
    logic [16:0]    act_thr_reg;

    logic           is_first, in_col, in_frame, fire, end_col, end_row, last0;
    logic [PXW-1:0] end_x;
    logic [PYW-1:0] end_y;

    assign is_first = (vx_reg == '0) && (vy_reg == '0);
    assign in_col   = is_first || (vx_reg < PXW'(act_w_reg));
    assign in_frame = is_first || (in_col && (vy_reg < PYW'(act_h_reg)));
    assign s_ready  = (state_reg == ST_SCAN) && in_frame;
    assign fire     = (state_reg == ST_SCAN) && (in_frame ? s_valid : 1'b1);
    assign end_x    = PXW'(act_w_reg) + PXW'(act_r_reg) - PXW'(1);
    assign end_y    = PYW'(act_h_reg) + PYW'(act_r_reg) - PYW'(1);
    assign end_col  = (vx_reg == end_x);
    assign end_row  = (vy_reg == end_y);
    assign last0    = end_col && end_row;

    logic v3_reg, last3_reg;
    logic emit_go;
    assign emit_go = (state_reg == ST_EMIT) && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SCAN;
            vx_reg    <= '0;
            vy_reg    <= '0;
        end else begin
            case (state_reg)
                ST_SCAN: begin
                    if (fire) begin
                        if (end_col) begin
                            vx_reg <= '0;
                            if (end_row) begin
                                vy_reg    <= '0;
                                state_reg <= ST_DRAIN;
                            end else begin
                                vy_reg <= vy_reg + PYW'(1);
                            end
                        end else begin
                            vx_reg <= vx_reg + PXW'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (v3_reg && last3_reg) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        state_reg <= ST_SCAN;
                    end
                end
                default: state_reg <= ST_SCAN;
            endcase
        end
    end

    // latch geometry and threshold at the first pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_w_reg   <= WW'(RST_FRAME_WIDTH);
            act_h_reg   <= HW'(RST_FRAME_HEIGHT);
            act_r_reg   <= RW'(RST_WINDOW_RAD);
            act_thr_reg <= RST_THRESHOLD;
        end else if (fire && is_first) begin
            act_w_reg   <= w_eff;
            act_h_reg   <= h_eff;
            act_r_reg   <= r_eff;
            act_thr_reg <= threshold_reg;
        end
    end

    // stage 0: gray conversion
    logic [23:0] gray_sum;
    assign gray_sum = 24'(s_data.red) * 24'(COEF_R) + 24'(s_data.green) * 24'(COEF_G)
                    + 24'(s_data.blue) * 24'(COEF_B) + GRAY_RND;

    logic           v1_reg, incol1_reg, clear1_reg, judge1_reg, last1_reg;
    logic [7:0]     gray1_reg, level1_reg;
    logic [PXW-1:0] vx1_reg;
    logic [PYW-1:0] vy1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            gray1_reg  <= in_frame ? gray_sum[23:16] : 8'd0;
            level1_reg <= in_frame ? s_data.reference_level : 8'd0;
            vx1_reg    <= vx_reg;
            vy1_reg    <= vy_reg;
            incol1_reg <= in_col;
            clear1_reg <= (vx_reg == '0);
            judge1_reg <= (vy_reg >= PYW'(act_r_reg)) && (vx_reg >= PXW'(act_r_reg));
            last1_reg  <= last0;
        end
    end

    // column line memories: older gray rows and older levels per column
    logic [2*MAX_RADIUS-1:0][7:0] gmem [MAX_WIDTH];
    logic [MAX_RADIUS-1:0][7:0]   fmem [MAX_WIDTH];
    logic [2*MAX_RADIUS-1:0][7:0] g_rd_q, g_wr;
    logic [MAX_RADIUS-1:0][7:0]   f_rd_q, f_wr;

    always_ff @(posedge aclk) begin
        if (fire) begin
            g_rd_q <= gmem[vx_reg[AW-1:0]];
            f_rd_q <= fmem[vx_reg[AW-1:0]];
        end
        if (v1_reg && incol1_reg) begin
            gmem[vx1_reg[AW-1:0]] <= g_wr;
            fmem[vx1_reg[AW-1:0]] <= f_wr;
        end
    end

    // stage 1: column assembly and column sum
    logic [TAPS-1:0][7:0]     gcol;
    logic [MAX_RADIUS:0][7:0] fcol;
    logic [CSW-1:0]           col_sum;
    logic [7:0]               col_level;

    always_comb begin
        gcol[0] = incol1_reg ? gray1_reg : 8'd0;
        g_wr[0] = gray1_reg;
        for (int k = 1; k < TAPS; k++) begin
            gcol[k] = incol1_reg ? g_rd_q[k-1] : 8'd0;
        end
        for (int k = 1; k < 2 * MAX_RADIUS; k++) begin
            g_wr[k] = g_rd_q[k-1];
        end
        fcol[0] = level1_reg;
        f_wr[0] = level1_reg;
        for (int k = 1; k <= MAX_RADIUS; k++) begin
            fcol[k] = f_rd_q[k-1];
        end
        for (int k = 1; k < MAX_RADIUS; k++) begin
            f_wr[k] = f_rd_q[k-1];
        end
        col_sum = '0;
        for (int k = 0; k < TAPS; k++) begin
            if ((k <= 2 * int'(act_r_reg)) && (k <= int'(vy1_reg))) begin
                col_sum = col_sum + CSW'(gcol[k]);
            end
        end
        col_level = fcol[act_r_reg];
    end

    // row of window cells, newest column in cell 0
    logic [CDW-1:0] cell_q [TAPS];

    for (genvar j = 0; j < TAPS; j++) begin : g_cells
        logic [CDW-1:0] cell_d;
        if (j == 0) begin : g_head
            assign cell_d = {col_sum, col_level};
        end else begin : g_body
            assign cell_d = cell_q[j-1];
        end
        fmd_cell #(
            .DATA_W (CDW)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (v1_reg),
            .clear    ((j != 0) && clear1_reg),
            .d        (cell_d),
            .q        (cell_q[j])
        );
    end

    // stage 2: window sum
    logic v2_reg, judge2_reg, last2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        judge2_reg <= judge1_reg;
        last2_reg  <= last1_reg;
    end

    logic [WSW-1:0] win_sum;
    logic [7:0]     win_level;

    always_comb begin
        win_sum = '0;
        for (int j = 0; j < TAPS; j++) begin
            if (j <= 2 * int'(act_r_reg)) begin
                win_sum = win_sum + WSW'(cell_q[j][CDW-1:8]);
            end
        end
        win_level = cell_q[CIW'(act_r_reg)][7:0];
    end

    logic           judge3_reg;
    logic [WSW-1:0] sum3_reg;
    logic [7:0]     level3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sum3_reg   <= win_sum;
        level3_reg <= win_level;
        judge3_reg <= judge2_reg;
        last3_reg  <= last2_reg;
    end

    // stage 3: mean by reciprocal, compare, count
    logic [PRW-1:0] mean_prod;
    logic [7:0]     mean;
    logic [22:0]    count_reg;

    assign mean_prod = PRW'(sum3_reg) * PRW'(recip_of(3'(act_r_reg)));
    assign mean      = mean_prod[RECIP_SHIFT +: 8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (emit_go) begin
            count_reg <= '0;
        end else if (v3_reg && judge3_reg && (mean != level3_reg)) begin
            count_reg <= count_reg + 23'd1;
        end
    end

    // threshold side of the decision: area registered, then threshold times each area half
    logic [AREA_W-1:0]             area_reg;
    logic [THR_W+HALF-1:0]         thr_lo_reg;
    logic [THR_W+AREA_W-HALF-1:0]  thr_hi_reg;

    always_ff @(posedge aclk) begin
        area_reg   <= AREA_W'(act_w_reg) * AREA_W'(act_h_reg);
        thr_lo_reg <= (THR_W+HALF)'(act_thr_reg) * (THR_W+HALF)'(area_reg[HALF-1:0]);
        thr_hi_reg <= (THR_W+AREA_W-HALF)'(act_thr_reg)
                    * (THR_W+AREA_W-HALF)'(area_reg[AREA_W-1:HALF]);
    end

    logic [CMP_W-1:0] rhs, lhs;
    logic             flag;
    logic [31:0]      total_reg, total_next;

    assign rhs        = (CMP_W'(thr_hi_reg) << HALF) + CMP_W'(thr_lo_reg);
    assign lhs        = CMP_W'({count_reg, 16'd0});
    assign flag       = (lhs > rhs);
    assign total_next = total_reg + 32'(flag);

    // result register
    fmd_out_t m_data_reg;
    logic     m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
        end else if (emit_go) begin
            m_valid_reg <= 1'b1;
            total_reg   <= total_next;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            m_data_reg.differing_pixels <= count_reg;
            m_data_reg.frame_differs    <= flag;
            m_data_reg.flagged_frames   <= total_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && last0) |=> (state_reg == ST_DRAIN))
        else $error("scan did not stop after the last position");

    a_tail_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && last3_reg) |-> (state_reg == ST_DRAIN))
        else $error("frame tail reached the counter outside drain");

    a_emit_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> !(v1_reg || v2_reg || v3_reg))
        else $error("result taken with pixels still in the pipeline");

    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

endmodule

/* sim/frame_motion_detector_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_motion_detector_core_tb
// Streams raster frames through the motion detector under changing geometry,
// radius and threshold settings and checks every per-frame result against a
// behavioral scorer or set values, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module frame_motion_detector_core_tb;
    import fmd_pkg::*;

    localparam int LW = 2048;
    localparam int LH = 2048;
    localparam int LR = 3;
    localparam int GROWS = 2 * LR + 1;
    localparam int RROWS = LR + 1;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    fmd_in_t                s_data;
    logic                   m_valid;
    logic                   m_ready;
    fmd_out_t               m_data;

    frame_motion_detector_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // frame scorer
    // ------------------------------------------------------------------
    logic [7:0]  gray_rows [GROWS*LW];
    logic [7:0]  level_rows[RROWS*LW];
    int unsigned reg_w, reg_h, reg_r, reg_thr;
    int unsigned cur_w, cur_h, cur_r, cur_thr;
    int unsigned row_at, col_at, diff_count, flag_total;

    fmd_out_t    frame_results_q[$];
    int          err_count;
    int unsigned pixels_sent, frames_seen;
    int          send_idle_pct, recv_idle_pct;

    function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function void score_row(int c);
        int unsigned ssum, wsize, lbase, gbase;
        int yy, xx;
        wsize = (2 * cur_r + 1) * (2 * cur_r + 1);
        lbase = (c % RROWS) * LW;
        for (int x = 0; x < int'(cur_w); x++) begin
            ssum = 0;
            for (int dy = -int'(cur_r); dy <= int'(cur_r); dy++) begin
                yy = c + dy;
                if (yy < 0 || yy >= int'(cur_h)) continue;
                gbase = (yy % GROWS) * LW;
                for (int dx = -int'(cur_r); dx <= int'(cur_r); dx++) begin
                    xx = x + dx;
                    if (xx < 0 || xx >= int'(cur_w)) continue;
                    ssum += gray_rows[gbase + xx];
                end
            end
            if ((ssum / wsize) != level_rows[lbase + x])
                diff_count = (diff_count + 1) & 32'h7F_FFFF;
        end
    endfunction

    function bit score_pixel(input fmd_in_t px, output fmd_out_t res);
        int unsigned g;
        int first;
        longint unsigned lhs, rhs;
        bit flag;
        res = '0;
        if (row_at == 0 && col_at == 0) begin
            cur_w = clamp(reg_w, 1, LW);
            cur_h = clamp(reg_h, 1, LH);
            cur_r = clamp(reg_r, 1, LR);
            cur_thr = reg_thr;
            diff_count = 0;
        end
        g = (19589 * px.red + 38470 * px.green + 7471 * px.blue + 32768) >> 16;
        gray_rows[(row_at % GROWS) * LW + col_at] = g[7:0];
        level_rows[(row_at % RROWS) * LW + col_at] = px.reference_level;
        if (col_at + 1 < cur_w) begin
            col_at++;
            return 1'b0;
        end
        col_at = 0;
        if (row_at >= cur_r) score_row(row_at - cur_r);
        if (row_at + 1 < cur_h) begin
            row_at++;
            return 1'b0;
        end
        first = int'(row_at) - int'(cur_r) + 1;
        if (first < 0) first = 0;
        for (int c = first; c <= int'(row_at); c++) score_row(c);
        lhs = longint'(diff_count) * 65536;
        rhs = longint'(cur_thr) * cur_w * cur_h;
        flag = lhs > rhs;
        flag_total = flag_total + flag;
        res.differing_pixels = diff_count[22:0];
        res.frame_differs = flag;
        res.flagged_frames = flag_total;
        row_at = 0;
        diff_count = 0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val[CFG_DATA_W-1:0];
        case (idx)
            REG_FRAME_WIDTH:  reg_w = val & 12'hFFF;
            REG_FRAME_HEIGHT: reg_h = val & 12'hFFF;
            REG_WINDOW_RAD:   reg_r = val & 2'h3;
            REG_THRESHOLD:    reg_thr = val & 17'h1FFFF;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic wait_idle();
        while (frame_results_q.size() != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_pixel(fmd_in_t px, bit typed, fmd_out_t typed_res);
        fmd_out_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = px;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        if (score_pixel(px, res)) begin
            frames_seen++;
            frame_results_q.push_back(typed ? typed_res : res);
        end
        @(negedge aclk);
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned r, int unsigned t);
        s_valid = 1'b0;
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_WINDOW_RAD, r);
        write_reg(REG_THRESHOLD, t);
    endtask

    function automatic fmd_in_t rand_pixel(fmd_in_t base);
        fmd_in_t px;
        int unsigned g;
        px = base;
        case ($urandom_range(3))
            0: px = fmd_in_t'({24'($urandom), 8'($urandom)});
            1: begin
                px.red = base.red ^ 8'($urandom_range(3));
                px.green = base.green ^ 8'($urandom_range(3));
            end
            default: ;
        endcase
        g = (19589 * px.red + 38470 * px.green + 7471 * px.blue + 32768) >> 16;
        px.reference_level = ($urandom_range(1)) ? g[7:0] : 8'($urandom);
        return px;
    endfunction

    // ------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        fmd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_q.size() == 0) begin
                $display("%0t: expected no transfer, actual %p", $time, m_data);
                err_count++;
            end else begin
                want = frame_results_q.pop_front();
                if (m_data.differing_pixels !== want.differing_pixels)
                    $display("%0t: differing_pixels expected %0d actual %0d", $time,
                             want.differing_pixels, m_data.differing_pixels);
                if (m_data.frame_differs !== want.frame_differs)
                    $display("%0t: frame_differs expected %0d actual %0d", $time,
                             want.frame_differs, m_data.frame_differs);
                if (m_data.flagged_frames !== want.flagged_frames)
                    $display("%0t: flagged_frames expected %0d actual %0d", $time,
                             want.flagged_frames, m_data.flagged_frames);
                if (m_data !== want) err_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        int unsigned val;
        fmd_in_t     px;
        bit          typed;
        fmd_out_t    res;
    } stim_row_t;

    stim_row_t dir_rows[$];

    function automatic stim_row_t cfg_row(logic [1:0] idx, int unsigned val);
        stim_row_t s;
        s = '{1'b1, idx, val, '0, 1'b0, '0};
        return s;
    endfunction

    function automatic stim_row_t pix_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] l, bit typed, int unsigned cnt,
                                          bit flag, int unsigned tot);
        stim_row_t s;
        s = '{1'b0, 2'd0, 0, '{r, g, b, l}, typed, '{cnt[22:0], flag, tot}};
        return s;
    endfunction

    initial begin
        fmd_in_t base;
        int unsigned w, h, quota, nfr;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        aresetn = 1'b0;
        err_count = 0;
        pixels_sent = 0;
        frames_seen = 0;
        send_idle_pct = 22;
        recv_idle_pct = 73;
        reg_w = RST_FRAME_WIDTH;
        reg_h = RST_FRAME_HEIGHT;
        reg_r = RST_WINDOW_RAD;
        reg_thr = RST_THRESHOLD;
        row_at = 0;
        col_at = 0;
        diff_count = 0;
        flag_total = 0;
        foreach (gray_rows[i]) gray_rows[i] = '0;
        foreach (level_rows[i]) level_rows[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // zero geometry and radius clamp to a 1x1 frame, radius 1
        dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 0));
        dir_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 0));
        dir_rows.push_back(cfg_row(REG_WINDOW_RAD, 0));
        dir_rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 8'd28, 1, 0, 0, 0));
        dir_rows.push_back(pix_row(8'h00, 8'h00, 8'h00, 8'hFF, 1, 1, 1, 1));
        dir_rows.push_back(cfg_row(REG_WINDOW_RAD, 3));
        dir_rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 8'd5, 1, 0, 0, 1));
        dir_rows.push_back(cfg_row(REG_THRESHOLD, 65536));
        dir_rows.push_back(pix_row(8'h00, 8'h00, 8'h00, 8'd1, 1, 1, 0, 1));
        dir_rows.push_back(cfg_row(REG_THRESHOLD, 131071));
        dir_rows.push_back(pix_row(8'h00, 8'h00, 8'h00, 8'd1, 1, 1, 0, 1));
        dir_rows.push_back(cfg_row(REG_THRESHOLD, 1));
        dir_rows.push_back(cfg_row(REG_FRAME_WIDTH, 3));
        dir_rows.push_back(cfg_row(REG_FRAME_HEIGHT, 2));
        dir_rows.push_back(cfg_row(REG_WINDOW_RAD, 2));
        dir_rows.push_back(pix_row(8'hFF, 8'h00, 8'h00, 8'd76, 0, 0, 0, 0));
        dir_rows.push_back(pix_row(8'h00, 8'hFF, 8'h00, 8'hFF, 0, 0, 0, 0));
        dir_rows.push_back(pix_row(8'h00, 8'h00, 8'hFF, 8'h00, 0, 0, 0, 0));
        dir_rows.push_back(pix_row(8'hAA, 8'h55, 8'hAA, 8'h55, 0, 0, 0, 0));
        dir_rows.push_back(pix_row(8'h55, 8'hAA, 8'h55, 8'hAA, 0, 0, 0, 0));
        dir_rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 8'd113, 0, 0, 0, 0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                s_valid = 1'b0;
                wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (int ph = 0; ph < 12; ph++) begin
            send_idle_pct = (ph < 4) ? 22 : (ph < 8) ? 73 : 0;
            recv_idle_pct = (ph < 4) ? 73 : (ph < 8) ? 22 : 0;
            quota = 90;
            nfr = 1000;
            if (ph == 1) begin
                configure(300, 1, 1, $urandom_range(1, 65536));
                nfr = 1;
            end else if (ph == 6) begin
                configure(1, 200, 3, $urandom_range(1, 65536));
                nfr = 1;
            end else begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 9);
                if (ph == 9) w = 100;
                if (ph == 9) h = 1;
                configure(w, h, $urandom_range(0, 3),
                          ($urandom_range(3) == 0) ? $urandom_range(65536, 131071)
                                                   : $urandom_range(1, 65536));
                w = clamp(w, 1, LW);
                h = clamp(h, 1, LH);
                nfr = (quota + w * h - 1) / (w * h);
                if (nfr < 2) nfr = 2;
            end
            for (int f = 0; f < int'(nfr); f++) begin
                base = fmd_in_t'({24'($urandom), 8'h00});
                for (int p = 0; p < int'(clamp(reg_w, 1, LW) * clamp(reg_h, 1, LH)); p++)
                    send_pixel(rand_pixel(base), 1'b0, '0);
            end
        end
        s_valid = 1'b0;

        while (frame_results_q.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        $display("Sent %0d pixels in %0d frames over 12 settings, radius 1..3,",
                 pixels_sent, frames_seen);
        $display("frame sizes 1x1 up to 300x1 and 1x200, thresholds 1 to above Q16 one");
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout waiting for transfers");
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* frame_motion_detector_core.f */
hdl/fmd_pkg.sv
hdl/fmd_cell.sv
hdl/frame_motion_detector_core.sv
sim/frame_motion_detector_core_tb.sv
